[rtl/core/jsrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsrc_pkg: shared types, constants and helpers for the joystick servo rate
// controller.
// ----------------------------------------------------------------------------
package jsrc_pkg;

    localparam int SampleWidth = 12;
    localparam int PulseWidth  = 12;
    localparam int ModeWidth   = 2;
    localparam int DelayWidth  = 4;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 12;

    typedef logic [SampleWidth-1:0] sample_t;
    typedef logic [PulseWidth-1:0]  pulse_t;
    typedef logic [ModeWidth-1:0]   mode_t;
    typedef logic [DelayWidth-1:0]  delay_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
    typedef logic [2:0]             step_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_CENTER_X        = 3'd0;
    localparam cfg_idx_t REG_CENTER_Y        = 3'd1;
    localparam cfg_idx_t REG_CENTER_PULSE    = 3'd2;
    localparam cfg_idx_t REG_MIN_PULSE       = 3'd3;
    localparam cfg_idx_t REG_MAX_PULSE       = 3'd4;
    localparam cfg_idx_t REG_DEADZONE_COARSE = 3'd5;
    localparam cfg_idx_t REG_DEADZONE_FINE   = 3'd6;

    // Reset values of the configuration registers.
    localparam sample_t RST_CENTER_X        = 12'd2048;
    localparam sample_t RST_CENTER_Y        = 12'd2048;
    localparam pulse_t  RST_CENTER_PULSE    = 12'd1450;
    localparam pulse_t  RST_MIN_PULSE       = 12'd500;
    localparam pulse_t  RST_MAX_PULSE       = 12'd2400;
    localparam sample_t RST_DEADZONE_COARSE = 12'd500;
    localparam sample_t RST_DEADZONE_FINE   = 12'd100;

    // Speed modes.
    localparam mode_t MODE_FAST   = 2'd0;
    localparam mode_t MODE_MEDIUM = 2'd1;
    localparam mode_t MODE_SLOW   = 2'd2;
    localparam mode_t MODE_UNUSED = 2'd3;

    function automatic mode_t mode_advance(mode_t m);
        mode_t r;
        unique case (m)
            MODE_FAST:   r = MODE_MEDIUM;
            MODE_MEDIUM: r = MODE_SLOW;
            MODE_SLOW:   r = MODE_FAST;
            default:     r = MODE_MEDIUM;
        endcase
        return r;
    endfunction

    function automatic step_t mode_step(mode_t m);
        step_t r;
        unique case (m)
            MODE_FAST:   r = 3'd5;
            MODE_MEDIUM: r = 3'd2;
            default:     r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic delay_t mode_delay(mode_t m);
        delay_t r;
        unique case (m)
            MODE_FAST:   r = 4'd5;
            MODE_MEDIUM: r = 4'd10;
            default:     r = 4'd15;
        endcase
        return r;
    endfunction

    // Clamp a signed candidate position; the lower limit is checked first,
    // so a value below it clamps to it even when the limits are inverted.
    function automatic pulse_t clamp_pulse(logic signed [PulseWidth+1:0] v,
                                           pulse_t lo, pulse_t hi);
        pulse_t r;
        priority if (v < $signed({2'b00, lo})) r = lo;
        else if (v > $signed({2'b00, hi}))     r = hi;
        else                                   r = v[PulseWidth-1:0];
        return r;
    endfunction

endpackage

[rtl/core/joystick_servo_rate_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_servo_rate_controller_top
// Pan/tilt servo rate controller driven by joystick ticks and two buttons.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------
//  in      | sink      | in_valid/in_ready  | joy_x, joy_y, speed_key,
//          |           |                    | center_button
//  out     | source    | out_valid/out_ready| pan_pulse, tilt_a_pulse,
//          |           |                    | tilt_b_pulse, speed_mode,
//          |           |                    | tick_delay_ms
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One tick is accepted per clock cycle while the result side is not
//  stalled. A tick lands in the input register, and a single pass of
//  compare, add and clamp logic then updates the controller state and the
//  result register; the state update is what limits the rate.
//  Reset clears the filters and the speed mode and puts all three servos at
//  the reset center pulse of 1450 us. A stalled result stays in the result
//  register while one more tick waits in the input register; only then does
//  in_ready drop. The cfg port is always ready and takes a write every cycle.
//
module joystick_servo_rate_controller_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  jsrc_pkg::sample_t      joy_x,
    input  jsrc_pkg::sample_t      joy_y,
    input  logic                   speed_key,
    input  logic                   center_button,
    output logic                   out_valid,
    input  logic                   out_ready,
    output jsrc_pkg::pulse_t       pan_pulse,
    output jsrc_pkg::pulse_t       tilt_a_pulse,
    output jsrc_pkg::pulse_t       tilt_b_pulse,
    output jsrc_pkg::mode_t        speed_mode,
    output jsrc_pkg::delay_t       tick_delay_ms,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  jsrc_pkg::cfg_idx_t     cfg_index,
    input  logic [jsrc_pkg::CfgDataWidth-1:0] cfg_data
);
    import jsrc_pkg::*;

    // Configuration registers.
    sample_t center_x_reg;
    sample_t center_y_reg;
    pulse_t  center_pulse_reg;
    pulse_t  min_pulse_reg;
    pulse_t  max_pulse_reg;
    sample_t deadzone_coarse_reg;
    sample_t deadzone_fine_reg;

    // Input register.
    logic    s1_valid_reg;
    sample_t s1_joy_x_reg;
    sample_t s1_joy_y_reg;
    logic    s1_speed_reg;
    logic    s1_center_reg;

    // Controller state; the positions and the mode also serve as the
    // result register, which only loads when a tick advances.
    sample_t filter_x_reg, filter_x_next;
    sample_t filter_y_reg, filter_y_next;
    pulse_t  pan_reg, pan_next;
    pulse_t  tilt_a_reg, tilt_a_next;
    pulse_t  tilt_b_reg, tilt_b_next;
    mode_t   mode_reg, mode_next;
    logic    last_speed_reg;
    logic    out_valid_reg;

    logic    s1_advance;

    // Tick datapath.
    logic [SampleWidth:0]          sum_x, sum_y;
    logic signed [SampleWidth:0]   dev_x, dev_y;
    logic [SampleWidth:0]          mag_x, mag_y;
    sample_t                       deadzone;
    step_t                         step;
    logic signed [PulseWidth+1:0]  step_pos, step_neg;
    logic signed [PulseWidth+1:0]  pan_move, tilt_move;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Configuration writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg        <= RST_CENTER_X;
            center_y_reg        <= RST_CENTER_Y;
            center_pulse_reg    <= RST_CENTER_PULSE;
            min_pulse_reg       <= RST_MIN_PULSE;
            max_pulse_reg       <= RST_MAX_PULSE;
            deadzone_coarse_reg <= RST_DEADZONE_COARSE;
            deadzone_fine_reg   <= RST_DEADZONE_FINE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X:        center_x_reg        <= cfg_data;
                REG_CENTER_Y:        center_y_reg        <= cfg_data;
                REG_CENTER_PULSE:    center_pulse_reg    <= cfg_data;
                REG_MIN_PULSE:       min_pulse_reg       <= cfg_data;
                REG_MAX_PULSE:       max_pulse_reg       <= cfg_data;
                REG_DEADZONE_COARSE: deadzone_coarse_reg <= cfg_data;
                REG_DEADZONE_FINE:   deadzone_fine_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_joy_x_reg  <= joy_x;
            s1_joy_y_reg  <= joy_y;
            s1_speed_reg  <= speed_key;
            s1_center_reg <= center_button;
        end
    end

    // One pass over the tick held in the input register.
    always_comb
    begin
        // A falling edge on the speed button advances the mode, even when
        // the center button is pressed in the same tick.
        if (!s1_speed_reg && last_speed_reg)
            mode_next = mode_advance(mode_reg);
        else
            mode_next = mode_reg;

        step     = mode_step(mode_next);
        deadzone = (mode_next >= MODE_SLOW) ? deadzone_fine_reg : deadzone_coarse_reg;

        sum_x = {1'b0, s1_joy_x_reg} + {1'b0, filter_x_reg};
        sum_y = {1'b0, s1_joy_y_reg} + {1'b0, filter_y_reg};

        dev_x = $signed({1'b0, sum_x[SampleWidth:1]}) - $signed({1'b0, center_x_reg});
        dev_y = $signed({1'b0, sum_y[SampleWidth:1]}) - $signed({1'b0, center_y_reg});
        mag_x = dev_x[SampleWidth] ? (SampleWidth+1)'(-dev_x) : dev_x;
        mag_y = dev_y[SampleWidth] ? (SampleWidth+1)'(-dev_y) : dev_y;

        step_pos  = $signed({{(PulseWidth-1){1'b0}}, step});
        step_neg  = -step_pos;
        pan_move  = dev_x[SampleWidth] ? step_neg : step_pos;
        tilt_move = dev_y[SampleWidth] ? step_neg : step_pos;

        filter_x_next = filter_x_reg;
        filter_y_next = filter_y_reg;
        pan_next      = pan_reg;
        tilt_a_next   = tilt_a_reg;
        tilt_b_next   = tilt_b_reg;

        if (!s1_center_reg)
        begin
            // Center press recenters all servos and leaves the filters.
            pan_next    = center_pulse_reg;
            tilt_a_next = center_pulse_reg;
            tilt_b_next = center_pulse_reg;
        end
        else
        begin
            filter_x_next = sum_x[SampleWidth:1];
            filter_y_next = sum_y[SampleWidth:1];
            if (mag_x > {1'b0, deadzone})
            begin
                pan_next = clamp_pulse($signed({2'b00, pan_reg}) + pan_move,
                                       min_pulse_reg, max_pulse_reg);
            end
            if (mag_y > {1'b0, deadzone})
            begin
                tilt_a_next = clamp_pulse($signed({2'b00, tilt_a_reg}) - tilt_move,
                                          min_pulse_reg, max_pulse_reg);
                tilt_b_next = clamp_pulse($signed({2'b00, tilt_b_reg}) + tilt_move,
                                          min_pulse_reg, max_pulse_reg);
            end
        end
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_x_reg   <= '0;
            filter_y_reg   <= '0;
            pan_reg        <= RST_CENTER_PULSE;
            tilt_a_reg     <= RST_CENTER_PULSE;
            tilt_b_reg     <= RST_CENTER_PULSE;
            mode_reg       <= MODE_FAST;
            last_speed_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                filter_x_reg   <= filter_x_next;
                filter_y_reg   <= filter_y_next;
                pan_reg        <= pan_next;
                tilt_a_reg     <= tilt_a_next;
                tilt_b_reg     <= tilt_b_next;
                mode_reg       <= mode_next;
                last_speed_reg <= s1_speed_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign pan_pulse     = pan_reg;
    assign tilt_a_pulse  = tilt_a_reg;
    assign tilt_b_pulse  = tilt_b_reg;
    assign speed_mode    = mode_reg;
    assign tick_delay_ms = mode_delay(mode_reg);

`ifndef SYNTHESIS
    // The mode never reaches the unused code.
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_UNUSED)
        else $error("speed mode reached the unused code");

    // A tick held in the input register stays there until it advances.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("pending tick lost from input register");

    // An advancing tick always presents a result in the next cycle.
    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced tick produced no result");

    // A center press leaves all three servos at the same position.
    a_center_equal: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_center_reg |=>
            (pan_reg == tilt_a_reg) && (tilt_a_reg == tilt_b_reg))
        else $error("center press left servos at different positions");

    // The reported delay follows the mode.
    a_delay_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((mode_reg == MODE_FAST && tick_delay_ms == 4'd5) ||
                           (mode_reg == MODE_MEDIUM && tick_delay_ms == 4'd10) ||
                           (mode_reg == MODE_SLOW && tick_delay_ms == 4'd15)))
        else $error("tick delay does not match speed mode");
`endif

endmodule

[verif/servo_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_result_checker
// Watches the tick, result and register channels of the joystick servo rate
// controller, predicts every result from its own copy of the controller state
// and compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module servo_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  jsrc_pkg::sample_t                 joy_x,
    input  jsrc_pkg::sample_t                 joy_y,
    input  logic                              speed_key,
    input  logic                              center_button,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  jsrc_pkg::pulse_t                  pan_pulse,
    input  jsrc_pkg::pulse_t                  tilt_a_pulse,
    input  jsrc_pkg::pulse_t                  tilt_b_pulse,
    input  jsrc_pkg::mode_t                   speed_mode,
    input  jsrc_pkg::delay_t                  tick_delay_ms,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  jsrc_pkg::cfg_idx_t                cfg_index,
    input  logic [jsrc_pkg::CfgDataWidth-1:0] cfg_data,
    output int                                mismatch_count,
    output int                                results_owed
);
    import jsrc_pkg::*;

    typedef struct packed {
        pulse_t pan;
        pulse_t tilt_a;
        pulse_t tilt_b;
        mode_t  mode;
        delay_t delay;
    } servo_result_t;

    servo_result_t servo_expected_q[$];

    // Register copies.
    sample_t ctr_x, ctr_y, dz_coarse, dz_fine;
    pulse_t  ctr_pulse, lo_pulse, hi_pulse;

    // Controller state copies.
    sample_t filt_x, filt_y;
    pulse_t  pan_pos, tilt_a_pos, tilt_b_pos;
    mode_t   mode_cur;
    logic    speed_last;

    task automatic report(string msg);
        if (mismatch_count < 50)
            $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // The lower limit is tested first, so a value below it clamps to it even when the limits cross.
    function automatic pulse_t limit_pulse(int v);
        pulse_t r;
        if (v < int'(lo_pulse))
            r = lo_pulse;
        else if (v > int'(hi_pulse))
            r = hi_pulse;
        else
            r = pulse_t'(v);
        return r;
    endfunction

    function automatic int step_size(mode_t m);
        int r;
        case (m)
            MODE_FAST:   r = 5;
            MODE_MEDIUM: r = 2;
            default:     r = 1;
        endcase
        return r;
    endfunction

    function automatic delay_t period_ms(mode_t m);
        delay_t r;
        case (m)
            MODE_FAST:   r = 4'd5;
            MODE_MEDIUM: r = 4'd10;
            default:     r = 4'd15;
        endcase
        return r;
    endfunction

    task automatic advance_servo_model(sample_t x, sample_t y, logic spd, logic ctr);
        servo_result_t r;
        int dz;
        int step;
        int dev;
        if (!spd && speed_last)
            mode_cur = (mode_cur == MODE_SLOW) ? MODE_FAST : mode_t'(mode_cur + 1'b1);
        speed_last = spd;
        if (!ctr) begin
            pan_pos    = ctr_pulse;
            tilt_a_pos = ctr_pulse;
            tilt_b_pos = ctr_pulse;
        end
        else begin
            step   = step_size(mode_cur);
            dz     = (mode_cur >= MODE_SLOW) ? int'(dz_fine) : int'(dz_coarse);
            filt_x = sample_t'((int'(x) + int'(filt_x)) >> 1);
            filt_y = sample_t'((int'(y) + int'(filt_y)) >> 1);
            dev = int'(filt_x) - int'(ctr_x);
            if ((dev < 0 ? -dev : dev) > dz)
                pan_pos = limit_pulse(int'(pan_pos) + (dev > 0 ? step : -step));
            dev = int'(filt_y) - int'(ctr_y);
            if ((dev < 0 ? -dev : dev) > dz) begin
                tilt_a_pos = limit_pulse(int'(tilt_a_pos) - (dev > 0 ? step : -step));
                tilt_b_pos = limit_pulse(int'(tilt_b_pos) + (dev > 0 ? step : -step));
            end
        end
        r.pan    = pan_pos;
        r.tilt_a = tilt_a_pos;
        r.tilt_b = tilt_b_pos;
        r.mode   = mode_cur;
        r.delay  = period_ms(mode_cur);
        servo_expected_q.push_back(r);
    endtask

    task automatic compare_result();
        servo_result_t want;
        if (servo_expected_q.size() == 0) begin
            report($sformatf("result pan=%0d arrived with nothing expected", pan_pulse));
            return;
        end
        want = servo_expected_q.pop_front();
        if (pan_pulse !== want.pan)
            report($sformatf("pan_pulse %0d, expected %0d", pan_pulse, want.pan));
        if (tilt_a_pulse !== want.tilt_a)
            report($sformatf("tilt_a_pulse %0d, expected %0d", tilt_a_pulse, want.tilt_a));
        if (tilt_b_pulse !== want.tilt_b)
            report($sformatf("tilt_b_pulse %0d, expected %0d", tilt_b_pulse, want.tilt_b));
        if (speed_mode !== want.mode)
            report($sformatf("speed_mode %0d, expected %0d", speed_mode, want.mode));
        if (tick_delay_ms !== want.delay)
            report($sformatf("tick_delay_ms %0d, expected %0d", tick_delay_ms, want.delay));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            servo_expected_q.delete();
            mismatch_count = 0;
            ctr_x      = RST_CENTER_X;
            ctr_y      = RST_CENTER_Y;
            ctr_pulse  = RST_CENTER_PULSE;
            lo_pulse   = RST_MIN_PULSE;
            hi_pulse   = RST_MAX_PULSE;
            dz_coarse  = RST_DEADZONE_COARSE;
            dz_fine    = RST_DEADZONE_FINE;
            filt_x     = '0;
            filt_y     = '0;
            pan_pos    = RST_CENTER_PULSE;
            tilt_a_pos = RST_CENTER_PULSE;
            tilt_b_pos = RST_CENTER_PULSE;
            mode_cur   = MODE_FAST;
            speed_last = 1'b1;
            results_owed <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER_X:        ctr_x     = cfg_data;
                    REG_CENTER_Y:        ctr_y     = cfg_data;
                    REG_CENTER_PULSE:    ctr_pulse = cfg_data;
                    REG_MIN_PULSE:       lo_pulse  = cfg_data;
                    REG_MAX_PULSE:       hi_pulse  = cfg_data;
                    REG_DEADZONE_COARSE: dz_coarse = cfg_data;
                    REG_DEADZONE_FINE:   dz_fine   = cfg_data;
                    default: ;
                endcase
            end
            // A result can never belong to a tick taken at the same edge.
            if (out_valid && out_ready)
                compare_result();
            if (in_valid && in_ready)
                advance_servo_model(joy_x, joy_y, speed_key, center_button);
            results_owed <= servo_expected_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the joystick servo rate controller: a short
// directed sequence, then joystick gestures with random content under a
// series of register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import jsrc_pkg::*;

    // Index 7 maps to no register; a write there must change nothing.
    localparam cfg_idx_t REG_UNMAPPED = 3'd7;

    // A correct run finishes well within this limit even with every stall at
    // its longest, so this only catches a hung handshake.
    localparam int CycleLimit = 400000;

    localparam int PhaseCount     = 8;
    localparam int ItemsPerPhase  = 190;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    sample_t  joy_x;
    sample_t  joy_y;
    logic     speed_key;
    logic     center_button;
    logic     out_valid;
    logic     out_ready;
    pulse_t   pan_pulse;
    pulse_t   tilt_a_pulse;
    pulse_t   tilt_b_pulse;
    mode_t    speed_mode;
    delay_t   tick_delay_ms;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    int mismatch_count;
    int results_owed;
    int cycle_count = 0;

    // Set for the last phase: from then on neither side idles.
    bit drain_calm = 1'b0;

    // Copy of the rest values and deadzones last written, used only to aim
    // the joystick gestures at the interesting thresholds.
    int rest_x;
    int rest_y;
    int dz_wide;
    int dz_narrow;

    joystick_servo_rate_controller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .joy_x         (joy_x),
        .joy_y         (joy_y),
        .speed_key     (speed_key),
        .center_button (center_button),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pan_pulse     (pan_pulse),
        .tilt_a_pulse  (tilt_a_pulse),
        .tilt_b_pulse  (tilt_b_pulse),
        .speed_mode    (speed_mode),
        .tick_delay_ms (tick_delay_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    servo_result_checker servo_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .joy_x          (joy_x),
        .joy_y          (joy_y),
        .speed_key      (speed_key),
        .center_button  (center_button),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pan_pulse      (pan_pulse),
        .tilt_a_pulse   (tilt_a_pulse),
        .tilt_b_pulse   (tilt_b_pulse),
        .speed_mode     (speed_mode),
        .tick_delay_ms  (tick_delay_ms),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a stuck handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side back-pressure. Stalls alternate with ready stretches,
    // some of them long, so that stalls land on every phase of the
    // two-stage pipeline and also let the input register fill.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (drain_calm) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic sample_t sat12(int v);
        sample_t r;
        if (v < 0)
            r = '0;
        else if (v > 4095)
            r = '1;
        else
            r = sample_t'(v);
        return r;
    endfunction

    // One tick transaction. Valid is raised (or simply kept high) and the
    // task returns at the edge where the tick was taken, leaving valid high;
    // whoever idles next lowers it, so valid never drops and rises in one step.
    task automatic send_tick(sample_t x, sample_t y, logic spd, logic ctr);
        in_valid      <= 1'b1;
        joy_x         <= x;
        joy_y         <= y;
        speed_key     <= spd;
        center_button <= ctr;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataWidth'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Registers are only touched once the block has handed back every
    // result, so the controller is idle while the settings change. Every
    // tick yields a result, so no further settling time is needed.
    task automatic apply_settings(int cx, int cy, int cp, int lo, int hi,
                                  int dc, int df, bit poke_unmapped);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_PULSE, cp);
        write_reg(REG_MIN_PULSE, lo);
        write_reg(REG_MAX_PULSE, hi);
        write_reg(REG_DEADZONE_COARSE, dc);
        write_reg(REG_DEADZONE_FINE, df);
        if (poke_unmapped)
            write_reg(REG_UNMAPPED, $urandom_range(0, 4095));
        cfg_valid <= 1'b0;
        rest_x    = cx;
        rest_y    = cy;
        dz_wide   = dc;
        dz_narrow = df;
    endtask

    // Target for one axis of a gesture. Holding a value exactly one deadzone
    // above rest, approached from above, parks the filter on the
    // threshold itself, where no step may happen.
    function automatic sample_t pick_axis(int rest, int dz);
        sample_t r;
        case ($urandom_range(0, 6))
            0:       r = '0;
            1:       r = '1;
            2:       r = sample_t'($urandom);
            3:       r = sat12(rest);
            4:       r = sat12(rest + dz);
            5:       r = sat12(rest - dz);
            default: r = sat12(rest + dz + 1);
        endcase
        return r;
    endfunction

    // Gestures: the stick is held on a target for up to 60 ticks, long
    // enough for the filters to settle and for the servos to run into their
    // limits. A few gestures are pure noise. The speed button is tapped now
    // and then and the center button is pressed now and then; some gestures
    // run with the tick source never idling.
    task automatic run_gestures(int count);
        int      sent;
        int      hold;
        int      dz;
        bit      noisy;
        bit      steady;
        sample_t tx;
        sample_t ty;
        sample_t x;
        sample_t y;
        logic    spd;
        logic    ctr;
        sent = 0;
        spd  = 1'b1;
        while (sent < count) begin
            dz     = $urandom_range(0, 1) ? dz_wide : dz_narrow;
            tx     = pick_axis(rest_x, dz);
            ty     = pick_axis(rest_y, dz);
            noisy  = ($urandom_range(0, 7) == 0);
            steady = ($urandom_range(0, 2) == 0);
            hold   = $urandom_range(1, 60);
            for (int i = 0; i < hold && sent < count; i++) begin
                x = noisy ? sample_t'($urandom) : tx;
                y = noisy ? sample_t'($urandom) : ty;
                if (spd)
                    spd = ($urandom_range(0, 19) != 0);
                else
                    spd = $urandom_range(0, 1);
                ctr = ($urandom_range(0, 24) != 0);
                if (!steady && !drain_calm && $urandom_range(0, 4) == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                end
                send_tick(x, y, spd, ctr);
                sent++;
            end
        end
    endtask

    initial
    begin
        int cp;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        joy_x         = '0;
        joy_y         = '0;
        speed_key     = 1'b1;
        center_button = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CENTER_X;
        cfg_data      = '0;
        rest_x        = RST_CENTER_X;
        rest_y        = RST_CENTER_Y;
        dz_wide       = RST_DEADZONE_COARSE;
        dz_narrow     = RST_DEADZONE_FINE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset settings, starting in fast mode.
        send_tick('0, '0, 1'b1, 1'b1);
        // Full scale pushes both filters past the coarse deadzone.
        repeat (4) send_tick('1, '1, 1'b1, 1'b1);
        // Center press recenters the servos and leaves the filters alone.
        send_tick('1, '0, 1'b1, 1'b0);
        // Speed press moves to medium; holding it does not advance again.
        send_tick('1, '0, 1'b0, 1'b1);
        send_tick('1, '0, 1'b0, 1'b1);
        send_tick('0, '1, 1'b1, 1'b1);
        // A speed press together with a center press still advances, to slow.
        send_tick(12'd2048, 12'd2048, 1'b0, 1'b0);
        // Slow mode: fine deadzone and single microsecond steps.
        repeat (3) send_tick('0, '1, 1'b1, 1'b1);
        send_tick(12'd2048, 12'd2048, 1'b1, 1'b1);
        // Another press wraps from slow back to fast.
        send_tick('0, '0, 1'b0, 1'b1);
        send_tick('1, '1, 1'b1, 1'b1);
        send_tick(12'hAAA, 12'h555, 1'b1, 1'b1);
        send_tick(12'h555, 12'hAAA, 1'b1, 1'b1);

        for (int p = 0; p < PhaseCount; p++) begin
            case (p)
                0: begin
                    cp = $urandom_range(1000, 2000);
                    apply_settings($urandom_range(1800, 2300), $urandom_range(1800, 2300),
                                   cp, 500, 2400, $urandom_range(0, 800),
                                   $urandom_range(0, 200), 1'b0);
                end
                // Everything at zero: any deviation steps; the clamps hold 0.
                1: apply_settings(0, 0, 0, 0, 0, 0, 0, 1'b0);
                // Everything at full scale: no deviation can exceed the deadzone.
                2: apply_settings(4095, 4095, 4095, 4095, 4095, 4095, 4095, 1'b0);
                // Crossed limits: a value below the lower limit must clamp to it.
                3: apply_settings(2048, 2048, 1500, 2000, 1000, 300, 60, 1'b1);
                // Narrow window around center, so the clamps bite quickly.
                4: begin
                    cp = $urandom_range(100, 4000);
                    apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                                   cp, cp - 20, cp + 20, 1, 0, 1'b0);
                end
                // Rest values at opposite ends of the range.
                5: apply_settings(4095, 0, 2048, 0, 4095, 4095, 0, 1'b0);
                6: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), 1'b1);
                default: begin
                    // Back to the reset settings for a run with no idling.
                    apply_settings(RST_CENTER_X, RST_CENTER_Y, RST_CENTER_PULSE,
                                   RST_MIN_PULSE, RST_MAX_PULSE, RST_DEADZONE_COARSE,
                                   RST_DEADZONE_FINE, 1'b0);
                    drain_calm = 1'b1;
                end
            endcase
            run_gestures(ItemsPerPhase);
        end

        // Drain: every expected result must come back, then the bench waits on
        // to catch anything extra the block might still emit.
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/jsrc_pkg.sv
rtl/core/joystick_servo_rate_controller_top.sv
verif/servo_result_checker.sv
verif/tb_top.sv
